>>> rtl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	localparam int ADDR_W = 5;

	// Fixed constants of the compensation formulas
	localparam int B5_OFFSET = 4000;
	localparam int B4_BIAS   = 32768;
	localparam int OSS_SCALE = 50000;
	localparam int P_C1      = 3038;
	localparam int P_C2      = -7357;
	localparam int P_C3      = 3791;
	localparam int T_MAX     = 32767;
	localparam int T_MIN     = -32768;
	localparam int P_MAX     = 262143;

	// Unpacked calibration set
	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [1:0]         oss;
	} coef_t;

endpackage

>>> rtl/ptc_cfg.sv
// Configuration register file with an APB-style port.
module ptc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output ptc_pkg::coef_t            coef
);
	import ptc_pkg::*;

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;
	logic [2:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (wr) begin
			case (idx)
				REG_AC1_AC2: ac12_q <= pwdata;
				REG_AC3_AC4: ac34_q <= pwdata;
				REG_AC5_AC6: ac56_q <= pwdata;
				REG_B1_B2:   b12_q  <= pwdata;
				REG_MC_MD:   mcmd_q <= pwdata;
				REG_OSS:     oss_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_AC1_AC2: prdata = ac12_q;
			REG_AC3_AC4: prdata = ac34_q;
			REG_AC5_AC6: prdata = ac56_q;
			REG_B1_B2:   prdata = b12_q;
			REG_MC_MD:   prdata = mcmd_q;
			REG_OSS:     prdata = {30'd0, oss_q};
			default:     prdata = '0;
		endcase
	end

	// Unpack coefficients
	assign coef.ac1 = signed'(ac12_q[31:16]);
	assign coef.ac2 = signed'(ac12_q[15:0]);
	assign coef.ac3 = signed'(ac34_q[31:16]);
	assign coef.ac4 = ac34_q[15:0];
	assign coef.ac5 = ac56_q[31:16];
	assign coef.ac6 = ac56_q[15:0];
	assign coef.b1  = signed'(b12_q[31:16]);
	assign coef.b2  = signed'(b12_q[15:0]);
	assign coef.mc  = signed'(mcmd_q[31:16]);
	assign coef.md  = signed'(mcmd_q[15:0]);
	assign coef.oss = oss_q;

endmodule

>>> rtl/ptc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module ptc_div #(
	parameter int NW = 32,
	parameter int DW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	import ptc_pkg::*;

	logic          v_r    [0:NW];
	logic [NW-1:0] n_r    [0:NW];
	logic [NW-1:0] q_r    [0:NW];
	logic [DW-1:0] rem_r  [0:NW];
	logic [DW-1:0] d_r    [0:NW];
	logic [SW-1:0] side_r [0:NW];

	assign v_r[0]    = in_valid;
	assign n_r[0]    = num;
	assign q_r[0]    = '0;
	assign rem_r[0]  = '0;
	assign d_r[0]    = den;
	assign side_r[0] = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0]   trial, diff;
		logic          ge;
		logic [DW-1:0] nrem;

		// Shift in the next dividend bit and try a subtract
		assign trial = {rem_r[k], n_r[k][NW-1]};
		assign diff  = trial - {1'b0, d_r[k]};
		assign ge    = trial >= {1'b0, d_r[k]};
		assign nrem  = ge ? diff[DW-1:0] : trial[DW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[k+1] <= 1'b0;
			end else if (en) begin
				v_r[k+1] <= v_r[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_r[k+1]    <= n_r[k] << 1;
				q_r[k+1]    <= {q_r[k][NW-2:0], ge};
				rem_r[k+1]  <= nrem;
				d_r[k+1]    <= d_r[k];
				side_r[k+1] <= side_r[k];
			end
		end
	end

	assign out_valid = v_r[NW];
	assign quo       = q_r[NW];
	assign side_out  = side_r[NW];

endmodule

>>> rtl/pressure_temperature_compensation.sv
// Top level: pipelined barometric pressure and temperature compensation.
//
//  channel   handshake               words
//  raw       raw_valid / raw_stall   raw_temperature, raw_pressure
//  result    result_valid / result_stall  temperature, pressure, divide_error
//  config    psel penable pwrite pready   paddr, pwdata, prdata
//
// One word enters per cycle while the result side is not stalled; the pipeline is the two
// bit-per-stage dividers (27 and 32 stages) plus ten arithmetic stages.
// Reset clears the valid bits and the config registers, not the payload registers; no clearing pass.
// A stalled result freezes the whole pipeline; raw_stall follows at once.
module pressure_temperature_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  logic [15:0]         raw_temperature,
	input  logic [23:0]         raw_pressure,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [15:0]  temperature,
	output logic [17:0]         pressure,
	output logic                divide_error,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ptc_pkg::*;

	localparam int SA_W = 43;
	localparam int SB_W = 18;

	coef_t c;
	logic  en;

	ptc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .coef(c)
	);

	// Advance everything unless the result is held
	assign en        = !(result_valid && result_stall);
	assign raw_stall = !en;

	// Stage 1: (UT - AC6) * AC5, align UP
	logic signed [17:0] d1;
	logic signed [34:0] p1;
	logic [23:0]        up_al;
	logic               v_s1;
	logic signed [31:0] prod_s1;
	logic [23:0]        up_s1;

	assign d1 = 18'(signed'({2'b0, raw_temperature})) - 18'(signed'({2'b0, c.ac6}));
	assign p1 = 35'(d1) * 35'(signed'({1'b0, c.ac5}));
	always_comb begin
		unique case (c.oss)
			2'd0: up_al = raw_pressure >> 8;
			2'd1: up_al = raw_pressure >> 7;
			2'd2: up_al = raw_pressure >> 6;
			2'd3: up_al = raw_pressure >> 5;
		endcase
	end

	// Stage 2: X1 = prod / 32768 toward zero, divisor X1 + MD, MC * 2048
	logic signed [32:0] r2;
	logic signed [16:0] x1_2;
	logic               v_s2;
	logic signed [16:0] x1_s2;
	logic signed [17:0] x2d_s2;
	logic signed [26:0] num_s2;
	logic [23:0]        up_s2;

	assign r2   = 33'(prod_s1) + (prod_s1[31] ? 33'sd32767 : 33'sd0);
	assign x1_2 = 17'(r2 >>> 15);

	// Divider A: magnitudes of MC*2048 over X1+MD
	logic [26:0]     na;
	logic [17:0]     da;
	logic [SA_W-1:0] sa_in, sa_out;
	logic            va;
	logic [26:0]     qa;

	assign na    = num_s2[26] ? 27'(-num_s2) : 27'(num_s2);
	assign da    = x2d_s2[17] ? 18'(-x2d_s2) : 18'(x2d_s2);
	assign sa_in = {x1_s2, up_s2, num_s2[26] ^ x2d_s2[17], x2d_s2 == 18'sd0};

	ptc_div #(.NW(27), .DW(18), .SW(SA_W)) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2), .num(na), .den(da),
		.side_in(sa_in), .out_valid(va), .quo(qa), .side_out(sa_out)
	);

	// Stage 3: B5 = X1 + X2
	logic signed [27:0] qs;
	logic               v_s3;
	logic signed [28:0] b5_s3;
	logic [23:0]        up_s3;
	logic               err_s3;

	assign qs = sa_out[1] ? -28'(signed'({1'b0, qa})) : 28'(signed'({1'b0, qa}));

	// Stage 4: T, B6 and B6 squared
	logic signed [29:0] tb;
	logic signed [29:0] tr;
	logic signed [25:0] tq;
	logic signed [15:0] tsat;
	logic signed [29:0] b6;
	logic signed [59:0] sqp;
	logic               v_s4;
	logic signed [15:0] t_s4;
	logic signed [29:0] b6_s4;
	logic [31:0]        sqp_s4;
	logic [23:0]        up_s4;
	logic               err_s4;

	assign tb = 30'(b5_s3) + 30'sd8;
	assign tr = tb + (tb[29] ? 30'sd15 : 30'sd0);
	assign tq = 26'(tr >>> 4);
	always_comb begin
		priority if (tq > 26'(T_MAX)) tsat = 16'(T_MAX);
		else if (tq < 26'(T_MIN))     tsat = 16'(T_MIN);
		else                          tsat = 16'(tq);
	end
	assign b6  = 30'(b5_s3) - 30'(B5_OFFSET);
	assign sqp = 60'(b6) * 60'(b6);

	// Stage 5: four coefficient products
	logic signed [31:0] sq;
	logic signed [47:0] m1, m2, m3, m4;
	logic               v_s5;
	logic signed [31:0] m1_s5, m2_s5, m3_s5, m4_s5;
	logic signed [15:0] t_s5;
	logic [23:0]        up_s5;
	logic               err_s5;

	assign sq = signed'(sqp_s4) >>> 12;
	assign m1 = 48'(c.b2) * 48'(sq);
	assign m4 = 48'(c.b1) * 48'(sq);
	assign m2 = 48'(c.ac2) * 48'(b6_s4);
	assign m3 = 48'(c.ac3) * 48'(b6_s4);

	// Stage 6: B3 and the B4 operand
	logic signed [31:0] x3a, b3a, b3b, b3c, x3b, x3c;
	logic               v_s6;
	logic signed [31:0] b3_s6, u_s6;
	logic signed [15:0] t_s6;
	logic [23:0]        up_s6;
	logic               err_s6;

	assign x3a = (m1_s5 >>> 11) + (m2_s5 >>> 11);
	assign b3a = (32'(c.ac1) <<< 2) + x3a;
	assign b3b = b3a <<< c.oss;
	assign b3c = b3b + 32'sd2;
	assign x3b = (m3_s5 >>> 13) + (m4_s5 >>> 16) + 32'sd2;
	assign x3c = x3b >>> 2;

	// Stage 7: B4 and B7
	logic [47:0] b4p, b7p;
	logic [31:0] b7d;
	logic [15:0] scale;
	logic        v_s7;
	logic [16:0] b4_s7;
	logic [31:0] b7_s7;
	logic signed [15:0] t_s7;
	logic        err_s7;

	assign b4p   = 48'(c.ac4) * 48'(unsigned'(u_s6));
	assign b7d   = 32'(up_s6) - unsigned'(b3_s6);
	assign scale = 16'(OSS_SCALE) >> c.oss;
	assign b7p   = 48'(b7d) * 48'(scale);

	// Divider B: B7 over B4, doubled before or after
	logic [31:0]     nb;
	logic [SB_W-1:0] sb_in, sb_out;
	logic            vb;
	logic [31:0]     qb;

	assign nb    = b7_s7[31] ? b7_s7 : (b7_s7 << 1);
	assign sb_in = {t_s7, b7_s7[31], err_s7};

	ptc_div #(.NW(32), .DW(17), .SW(SB_W)) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7), .num(nb), .den(b4_s7),
		.side_in(sb_in), .out_valid(vb), .quo(qb), .side_out(sb_out)
	);

	// Stage 8: P and the square term
	logic signed [31:0] p8, x8;
	logic signed [63:0] xxp, mp;
	logic               v_s8;
	logic signed [31:0] p_s8, xx_s8, mm_s8;
	logic signed [15:0] t_s8;
	logic               err_s8;

	assign p8  = signed'(sb_out[1] ? (qb << 1) : qb);
	assign x8  = p8 >>> 8;
	assign xxp = 64'(x8) * 64'(x8);
	assign mp  = 64'(32'(P_C2)) * 64'(p8);

	// Stage 9: scaled correction terms
	logic signed [63:0] ap;
	logic               v_s9;
	logic signed [31:0] a_s9, b_s9, p_s9;
	logic signed [15:0] t_s9;
	logic               err_s9;

	assign ap = 64'(xx_s8) * 64'(32'(P_C1));

	// Stage 10: final pressure, saturate, result register
	logic signed [31:0] corr, pf;
	logic [17:0]        psat;

	assign corr = a_s9 + b_s9 + 32'(P_C3);
	assign pf   = p_s9 + (corr >>> 4);
	always_comb begin
		priority if (pf < 32'sd0)      psat = '0;
		else if (pf > 32'(P_MAX))      psat = 18'(P_MAX);
		else                           psat = 18'(pf);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= raw_valid;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= vb;
			v_s9 <= v_s8;
			result_valid <= v_s9;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= p1[31:0];
			up_s1   <= up_al;

			x1_s2   <= x1_2;
			x2d_s2  <= 18'(x1_2) + 18'(c.md);
			num_s2  <= 27'(c.mc) <<< 11;
			up_s2   <= up_s1;

			b5_s3   <= 29'(signed'(sa_out[SA_W-1 -: 17])) + 29'(qs);
			up_s3   <= sa_out[25:2];
			err_s3  <= sa_out[0];

			t_s4    <= tsat;
			b6_s4   <= b6;
			sqp_s4  <= sqp[31:0];
			up_s4   <= up_s3;
			err_s4  <= err_s3;

			m1_s5   <= m1[31:0];
			m2_s5   <= m2[31:0];
			m3_s5   <= m3[31:0];
			m4_s5   <= m4[31:0];
			t_s5    <= t_s4;
			up_s5   <= up_s4;
			err_s5  <= err_s4;

			b3_s6   <= b3c >>> 2;
			u_s6    <= x3c + 32'(B4_BIAS);
			t_s6    <= t_s5;
			up_s6   <= up_s5;
			err_s6  <= err_s5;

			b4_s7   <= b4p[31:15];
			b7_s7   <= b7p[31:0];
			t_s7    <= t_s6;
			err_s7  <= err_s6 || (b4p[31:15] == 17'd0);

			p_s8    <= p8;
			xx_s8   <= xxp[31:0];
			mm_s8   <= mp[31:0];
			t_s8    <= signed'(sb_out[SB_W-1 -: 16]);
			err_s8  <= sb_out[0];

			a_s9    <= signed'(ap[31:0]) >>> 16;
			b_s9    <= mm_s8 >>> 16;
			p_s9    <= p_s8;
			t_s9    <= t_s8;
			err_s9  <= err_s8;

			temperature  <= err_s9 ? 16'sd0 : t_s9;
			pressure     <= err_s9 ? 18'd0 : psat;
			divide_error <= err_s9;
		end
	end

	// A flagged result carries zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && divide_error |-> temperature == 16'sd0 && pressure == 18'd0)
		else $error("divide_error result with nonzero fields");

	// A held pipeline keeps its entry stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(prod_s1))
		else $error("entry stage changed while held");

	// Stall on the raw side only when a result waits
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		raw_stall |-> result_valid)
		else $error("raw side stalled with no result waiting");

endmodule
